// File: rtl/ham_pkg.sv
// ----------------------------------------------------------------------------
// ham_pkg
// Shared types and constants for the Hopfield associative memory.
// ----------------------------------------------------------------------------
package ham_pkg;
	localparam int MaxNeurons = 64;
	localparam int WeightBits = 8;
	localparam int IdxW = $clog2(MaxNeurons);
	localparam int CntW = IdxW + 1;
	localparam int AddrW = 2 * IdxW;
	localparam int SumW = WeightBits + IdxW + 1;
	localparam logic signed [WeightBits-1:0] WMax = {1'b0, {(WeightBits-1){1'b1}}};
	localparam logic signed [WeightBits-1:0] WMin = {1'b1, {(WeightBits-1){1'b0}}};

	typedef enum logic [1:0] {
		FUNC_CLEAR  = 2'd0,
		FUNC_TRAIN  = 2'd1,
		FUNC_RECALL = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_TRAIN  = 2'd1,
		CMD_RECALL = 2'd2
	} cmd_kind_t;

	// command from front to back; pattern snapshot travels with it
	typedef struct packed {
		cmd_kind_t            kind;
		logic [CntW-1:0]      n;
		logic [MaxNeurons-1:0] pat;
	} cmd_t;
endpackage

// File: rtl/ham_front.sv
// ----------------------------------------------------------------------------
// ham_front
// Gathers pattern elements and issues clear, train and recall commands.
// ----------------------------------------------------------------------------
module ham_front import ham_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  logic [1:0]      func,
	input  logic            value,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [6:0]      cfg_data,
	output logic            cmd_valid,
	input  logic            cmd_ready,
	output cmd_t            cmd
);
	logic [CntW-1:0]       count_q;
	logic [CntW-1:0]       elem_q;
	logic [MaxNeurons-1:0] pat_q;
	logic [CntW-1:0]       n;
	logic [CntW-1:0]       elem;
	logic [MaxNeurons-1:0] pat_nx;
	logic                  acc;
	logic                  done;
	logic                  issue;

	always_comb begin
		if (count_q < CntW'(2)) n = CntW'(2);
		else if (count_q > CntW'(MaxNeurons)) n = CntW'(MaxNeurons);
		else n = count_q;
		elem = (elem_q >= n) ? '0 : elem_q;
		pat_nx = pat_q;
		pat_nx[elem[IdxW-1:0]] = value;
	end

	// a config beat takes the cycle; items wait for it
	assign full = (cmd_valid && !cmd_ready) || cfg_valid;
	assign cfg_ready = 1'b1;
	assign acc = push && !full;
	assign done = (elem + CntW'(1)) >= n;
	assign issue = acc && ((func_t'(func) == FUNC_CLEAR) ||
		((func_t'(func) inside {FUNC_TRAIN, FUNC_RECALL}) && done));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CntW'(MaxNeurons);
			elem_q <= '0;
			pat_q <= '0;
			cmd_valid <= 1'b0;
			cmd <= '0;
		end else begin
			if (issue) cmd_valid <= 1'b1;
			else if (cmd_valid && cmd_ready) cmd_valid <= 1'b0;
			if (cfg_valid) begin
				count_q <= cfg_data;
				elem_q <= '0;
			end else if (acc) begin
				case (func_t'(func))
					FUNC_CLEAR: begin
						elem_q <= '0;
						cmd.kind <= CMD_CLEAR;
					end
					FUNC_TRAIN, FUNC_RECALL: begin
						pat_q <= pat_nx;
						if (done) begin
							elem_q <= '0;
							cmd.kind <= (func_t'(func) == FUNC_TRAIN) ? CMD_TRAIN : CMD_RECALL;
							cmd.n <= n;
							cmd.pat <= pat_nx;
						end else begin
							elem_q <= elem + CntW'(1);
						end
					end
					default: ;
				endcase
			end
		end
	end
endmodule

// File: rtl/ham_back.sv
// ----------------------------------------------------------------------------
// ham_back
// Weight memory sequencer: clear sweep, Hebbian train, one-step recall.
// ----------------------------------------------------------------------------
module ham_back import ham_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  cmd_t             cmd,
	output logic             empty,
	input  logic             pop,
	output logic [IdxW-1:0]  neuron_index,
	output logic             value_res,
	output logic             last
);
	typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

	logic signed [WeightBits-1:0] mem [MaxNeurons*MaxNeurons];
	state_t                state_q;
	cmd_t                  c_q;
	logic [IdxW-1:0]       i_q, j_q;
	logic                  rd_v_s1, row_end_s1;
	logic [IdxW-1:0]       i_s1, j_s1;
	logic signed [WeightBits-1:0] rd_s1;
	logic signed [SumW-1:0] sum_q;
	logic signed [SumW-1:0] sum_nx;
	logic signed [WeightBits:0] tw;
	logic                  out_en;
	logic                  nv;
	logic                  last_i, last_j;
	logic                  adv;
	logic                  emit;

	assign cmd_ready = (state_q == S_IDLE);
	assign last_i = (CntW'(i_q) == c_q.n - CntW'(1));
	assign last_j = (CntW'(j_q) == c_q.n - CntW'(1));
	// recall emits when output slot free
	assign out_en = empty || pop;
	assign emit = rd_v_s1 && c_q.kind == CMD_RECALL && out_en && row_end_s1;

	always_comb begin
		sum_nx = sum_q + ((c_q.pat[j_s1]) ? SumW'(rd_s1) : -SumW'(rd_s1));
		if (sum_nx > 0) nv = 1'b1;
		else if (sum_nx < 0) nv = 1'b0;
		else nv = c_q.pat[i_s1];
		tw = (WeightBits+1)'(rd_s1) +
			((c_q.pat[i_s1] == c_q.pat[j_s1]) ? (WeightBits+1)'(1) : -(WeightBits+1)'(1));
	end

	// one weight per cycle; recall stalls the walk when the result slot is busy
	assign adv = (state_q == S_RUN) && !(c_q.kind == CMD_RECALL && !out_en);

	always_ff @(posedge clk) begin
		if (adv) rd_s1 <= mem[{i_q, j_q}];
		if (state_q == S_RUN && c_q.kind == CMD_CLEAR) mem[{i_q, j_q}] <= '0;
		else if (rd_v_s1 && c_q.kind == CMD_TRAIN && i_s1 != j_s1) begin
			if (tw > (WeightBits+1)'(WMax)) mem[{i_s1, j_s1}] <= WMax;
			else if (tw < (WeightBits+1)'(WMin)) mem[{i_s1, j_s1}] <= WMin;
			else mem[{i_s1, j_s1}] <= tw[WeightBits-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RUN;
			c_q.kind <= CMD_CLEAR;
			c_q.n <= CntW'(MaxNeurons);
			c_q.pat <= '0;
			i_q <= '0;
			j_q <= '0;
			i_s1 <= '0;
			j_s1 <= '0;
			rd_v_s1 <= 1'b0;
			row_end_s1 <= 1'b0;
			empty <= 1'b1;
			neuron_index <= '0;
			value_res <= 1'b0;
			last <= 1'b0;
			sum_q <= '0;
		end else begin
			if (emit) empty <= 1'b0;
			else if (pop && !empty) empty <= 1'b1;
			if (c_q.kind != CMD_RECALL || out_en) rd_v_s1 <= adv && c_q.kind != CMD_CLEAR;
			if (adv) begin
				i_s1 <= i_q;
				j_s1 <= j_q;
				row_end_s1 <= last_j;
			end
			if (rd_v_s1 && c_q.kind == CMD_RECALL && out_en) begin
				sum_q <= row_end_s1 ? '0 : sum_nx;
				if (row_end_s1) begin
					neuron_index <= i_s1;
					value_res <= nv;
					last <= (CntW'(i_s1) == c_q.n - CntW'(1));
				end
			end
			case (state_q)
				S_IDLE: if (cmd_valid) begin
					c_q.kind <= cmd.kind;
					c_q.pat <= cmd.pat;
					c_q.n <= (cmd.kind == CMD_CLEAR) ? CntW'(MaxNeurons) : cmd.n;
					i_q <= '0;
					j_q <= '0;
					sum_q <= '0;
					state_q <= S_RUN;
				end
				S_RUN: if (adv) begin
					if (last_j) begin
						j_q <= '0;
						i_q <= i_q + IdxW'(1);
						if (last_i) state_q <= S_DONE;
					end else begin
						j_q <= j_q + IdxW'(1);
					end
				end
				S_DONE: if (c_q.kind != CMD_RECALL || out_en) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: rtl/hopfield_associative_memory.sv
// ----------------------------------------------------------------------------
// hopfield_associative_memory
// Hopfield memory: element gathering front, weight sequencer back.
// ----------------------------------------------------------------------------
// A completed pattern or a clear keeps the back busy after it takes the
// command (N is 64 for a clear): N*N weight accesses through separate
// RAM read and write ports, then the last write. Recall neuron i is out
// once its row is summed, later while pop stalls. A clearing pass runs
// after reset; elements are taken meanwhile and a completed command
// waits.
module hopfield_associative_memory import ham_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  logic [1:0]      func,
	input  logic            value,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [6:0]      cfg_data,
	output logic            empty,
	input  logic            pop,
	output logic [5:0]      neuron_index,
	output logic            value_res,
	output logic            last
);
	logic cmd_valid, cmd_ready;
	cmd_t cmd;

	ham_front u_front (
		.clk, .arst_n, .push, .full, .func, .value,
		.cfg_valid, .cfg_ready, .cfg_data,
		.cmd_valid, .cmd_ready, .cmd
	);

	ham_back u_back (
		.clk, .arst_n, .cmd_valid, .cmd_ready, .cmd,
		.empty, .pop, .neuron_index, .value_res, .last
	);
endmodule

// File: bench/ham_checker.sv
// ----------------------------------------------------------------------------
// ham_checker
// Predicts recall output of the Hopfield memory and compares each beat.
// ----------------------------------------------------------------------------
// Watches the item, config and result channels. A local weight matrix is
// trained and recalled in step with accepted items; expected neuron beats
// queue in order and are compared against every popped result.
module ham_checker import ham_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       full,
	input  logic [1:0] func,
	input  logic       value,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic [6:0] cfg_data,
	input  logic       empty,
	input  logic       pop,
	input  logic [5:0] neuron_index,
	input  logic       value_res,
	input  logic       last,
	output int         fail_count,
	output int         pending
);
	typedef struct packed {
		logic [5:0] idx;
		logic       val;
		logic       lst;
	} neuron_beat_t;

	logic signed [WeightBits-1:0] wgt [MaxNeurons][MaxNeurons];
	logic [MaxNeurons-1:0] pat;
	logic [6:0] elem_cnt;
	logic [6:0] ncount;
	neuron_beat_t recall_q[$];

	assign pending = recall_q.size();

	function automatic int eff_count();
		int n;
		n = ncount;
		if (n < 2) n = 2;
		if (n > MaxNeurons) n = MaxNeurons;
		return n;
	endfunction

	task automatic clear_weights();
		foreach (wgt[i, j]) wgt[i][j] = '0;
	endtask

	task automatic hebb_train(int n);
		int w;
		for (int i = 0; i < n; i++)
			for (int j = 0; j < n; j++) begin
				if (i == j) continue;
				w = int'(wgt[i][j]) + ((pat[i] == pat[j]) ? 1 : -1);
				if (w > int'(WMax)) w = int'(WMax);
				if (w < int'(WMin)) w = int'(WMin);
				wgt[i][j] = w[WeightBits-1:0];
			end
	endtask

	task automatic recall_step(int n);
		int sum;
		neuron_beat_t b;
		for (int i = 0; i < n; i++) begin
			sum = 0;
			for (int j = 0; j < n; j++)
				sum += int'(wgt[i][j]) * (pat[j] ? 1 : -1);
			b.idx = i[5:0];
			b.val = (sum > 0) ? 1'b1 : (sum < 0) ? 1'b0 : pat[i];
			b.lst = (i == n - 1);
			recall_q.push_back(b);
		end
	endtask

	task automatic take_item(func_t f, logic v);
		int n;
		n = eff_count();
		if (f == FUNC_CLEAR) begin
			clear_weights();
			elem_cnt = '0;
			return;
		end
		if (f == FUNC_NONE) return;
		if (elem_cnt >= n) elem_cnt = '0;
		pat[elem_cnt[5:0]] = v;
		elem_cnt = elem_cnt + 7'd1;
		if (elem_cnt < n) return;
		elem_cnt = '0;
		if (f == FUNC_TRAIN) hebb_train(n);
		else recall_step(n);
	endtask

	always @(posedge clk or negedge arst_n) begin
		neuron_beat_t e;
		if (!arst_n) begin
			clear_weights();
			pat = '0;
			elem_cnt = '0;
			ncount = 7'd64;
			fail_count = 0;
			recall_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				ncount = cfg_data;
				elem_cnt = '0;
			end
			if (push && !full) take_item(func_t'(func), value);
			if (pop && !empty) begin
				if (recall_q.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected beat idx=%0d val=%0b last=%0b",
						$time, neuron_index, value_res, last);
				end else begin
					e = recall_q.pop_front();
					if (e.idx !== neuron_index || e.val !== value_res || e.lst !== last) begin
						fail_count++;
						$display("%0t: mismatch expected idx=%0d val=%0b last=%0b, got idx=%0d val=%0b last=%0b",
							$time, e.idx, e.val, e.lst, neuron_index, value_res, last);
					end
				end
			end
		end
	end
endmodule

// File: bench/tb_hopfield_associative_memory.sv
// ----------------------------------------------------------------------------
// tb_hopfield_associative_memory
// Stimulus and verdict for the Hopfield memory.
// ----------------------------------------------------------------------------
// Directed patterns at the size extremes, then random train/recall patterns
// over neuron counts 3 to 6, with random push and pop gaps in the first phase only.
module tb_hopfield_associative_memory;
	import ham_pkg::*;

	localparam int IdleLimit = 40000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic [1:0] func = '0;
	logic value = 1'b0;
	logic cfg_valid = 1'b0;
	logic [6:0] cfg_data = '0;
	logic pop = 1'b0;
	logic full, cfg_ready, empty, last, value_res;
	logic [5:0] neuron_index;
	int fail_count, pending;
	int idle_cycles = 0;
	bit calm = 1'b0;
	bit done = 1'b0;

	always #5 clk = ~clk;

	hopfield_associative_memory dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .func(func),
		.value(value), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data), .empty(empty), .pop(pop),
		.neuron_index(neuron_index), .value_res(value_res), .last(last)
	);

	ham_checker chk (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .func(func),
		.value(value), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data), .empty(empty), .pop(pop),
		.neuron_index(neuron_index), .value_res(value_res), .last(last),
		.fail_count(fail_count), .pending(pending)
	);

	// receiver: random stalls except during the calm stretch
	always @(posedge clk) begin
		if (arst_n) pop <= calm ? 1'b1 : ($urandom_range(99) >= 36);
	end

	// watchdog on accepted beats of any channel
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit && !done) begin
			$display("FAILURE");
			$finish;
		end
	end

	// push stays high across back-to-back beats; random gaps and callers that pause drop it
	task automatic send_item(func_t f, logic v);
		if (!calm) begin
			while ($urandom_range(99) < 36) begin
				push <= 1'b0;
				@(posedge clk);
			end
		end
		push <= 1'b1;
		func <= f;
		value <= v;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	task automatic wait_results();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic drain();
		wait_results();
		// a train or clear may still be walking the weights
		repeat (4200) @(posedge clk);
	endtask

	task automatic write_count(logic [6:0] c);
		cfg_valid <= 1'b1;
		cfg_data <= c;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_pattern(func_t f, int n, logic [63:0] p);
		for (int i = 0; i < n; i++) send_item(f, p[i]);
	endtask

	int n;
	logic [63:0] stored [4];
	logic [63:0] probe;

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: smallest size, all funcs, both values
		write_count(7'd0);
		send_pattern(FUNC_TRAIN, 2, 64'b01);
		send_pattern(FUNC_RECALL, 2, 64'b01);
		send_pattern(FUNC_RECALL, 2, 64'b11);
		send_item(FUNC_NONE, 1'b1);
		// mixed pattern: train element then recall completes
		send_item(FUNC_TRAIN, 1'b0);
		send_item(FUNC_RECALL, 1'b0);
		// partial pattern dropped by clear
		send_item(FUNC_RECALL, 1'b1);
		send_item(FUNC_CLEAR, 1'b0);
		send_pattern(FUNC_RECALL, 2, 64'b10);
		drain();
		// count above the limit, partial dropped by the write
		write_count(7'd127);
		send_item(FUNC_TRAIN, 1'b1);
		drain();
		write_count(7'd64);
		send_pattern(FUNC_RECALL, 64, 64'hFFFF_0000_A5A5_5A5A);
		drain();
		write_count(7'd1);
		// repeated training of one pattern at the smallest size
		for (int k = 0; k < 3; k++) send_pattern(FUNC_TRAIN, 2, 64'b11);
		send_pattern(FUNC_RECALL, 2, 64'b10);
		// pressure: sender holds until results are out
		wait_results();

		// random: store two patterns, recall noisy versions
		for (int phase = 0; phase < 2; phase++) begin
			drain();
			n = $urandom_range(3, 6);
			write_count(n[6:0]);
			calm = (phase == 1);
			send_item(FUNC_CLEAR, 1'b0);
			for (int s = 0; s < 2; s++) begin
				stored[s] = {$urandom, $urandom};
				send_pattern(FUNC_TRAIN, n, stored[s]);
			end
			for (int r = 0; r < 3; r++) begin
				probe = stored[$urandom_range(1)] ^ (64'd1 << $urandom_range(n - 1));
				if ($urandom_range(9) == 0)
					send_item(func_t'(2'($urandom_range(3))), 1'($urandom_range(1)));
				send_pattern(FUNC_RECALL, n, probe);
			end
		end
		calm = 1'b0;
		drain();
		done = 1'b1;
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

// File: hopfield_associative_memory.f
rtl/ham_pkg.sv
rtl/ham_front.sv
rtl/ham_back.sv
rtl/hopfield_associative_memory.sv
bench/ham_checker.sv
bench/tb_hopfield_associative_memory.sv
